@@ hdl/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, constants and helpers of the dynamic-threshold step counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  localparam int unsigned MAG_W   = 19;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned WIN_W   = 32;
  localparam int unsigned STEPS_W = 32;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned IN_TDATA_W  = 112;  // 105 bits used
  localparam int unsigned OUT_TDATA_W = 40;   // 36 bits used

  localparam int unsigned OFIFO_DEPTH = 8;
  localparam int unsigned OFIFO_AW    = 3;
  localparam int unsigned OFIFO_CW    = 4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BIAS_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_BIAS_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_BIAS_Z    = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP_PREC = 3'd3;
  localparam logic [IDX_W-1:0] REG_WINDOW_US = 3'd4;

  localparam logic [MAG_W-1:0] STEP_PREC_RST = 19'd200;
  localparam logic [WIN_W-1:0] WINDOW_US_RST = 32'd500000;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef logic [2:0][MAG_W-1:0] tri_mag_t;

  typedef struct packed {
    tri_mag_t          bias;        // two's complement per axis
    logic [MAG_W-1:0]  step_prec;
    logic [WIN_W-1:0]  window_us;
  } cfg_t;

  typedef struct packed {
    tri_mag_t          acc;         // two's complement per axis
    logic [TIME_W-1:0] time_us;
  } sample_t;

  typedef struct packed {
    logic              valid;
    tri_mag_t          avg;
    logic [TIME_W-1:0] time_us;
  } avg_beat_t;

  typedef struct packed {
    logic [STEPS_W-1:0] total_steps;
    logic               step_seen;
    logic [1:0]         axis_in_use;
    logic               window_ended;
  } result_t;

  // |sample - bias|, saturated to the entry width
  function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] s,
                                              input logic [MAG_W-1:0] b);
    logic [MAG_W:0] d;
    logic [MAG_W:0] m;
    d = {s[MAG_W-1], s} - {b[MAG_W-1], b};
    m = d[MAG_W] ? (~d + 1'b1) : d;
    return m[MAG_W] ? {MAG_W{1'b1}} : m[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] pick(input tri_mag_t v, input axis_e a);
    logic [MAG_W-1:0] r;
    case (a)
      AXIS_Y:  r = v[1];
      AXIS_Z:  r = v[2];
      default: r = v[0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/dts_avg.sv @@
// ----------------------------------------------------------------------------
// dts_avg
// Bias removal, magnitude, per-axis moving average over a ring memory.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_avg #(
  parameter int unsigned AVG_LEN = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  dts_pkg::sample_t   sample_i,
  input  dts_pkg::cfg_t      cfg_i,
  output dts_pkg::avg_beat_t beat_o
);
  import dts_pkg::*;

  localparam int unsigned PTR_W  = $clog2(AVG_LEN);
  localparam int unsigned SUM_W  = MAG_W + PTR_W;
  localparam int unsigned SHIFT  = SUM_W + PTR_W;
  localparam int unsigned PROD_W = 2 * SUM_W + 1;
  // exact floor(sum / AVG_LEN) = (sum * RECIP) >> SHIFT for any sum < 2^SUM_W
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << SHIFT) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN));

  // ring memory, all three axes in one row
  tri_mag_t             mem_q [AVG_LEN];
  logic [AVG_LEN-1:0]   row_ok_q;
  tri_mag_t             rd_q;
  logic                 rd_ok_q;
  logic [PTR_W-1:0]     ptr_q, ptr_d;

  logic                 p1_valid_q, p2_valid_q, p3_valid_q;
  tri_mag_t             p1_mag_q;
  logic [PTR_W-1:0]     p1_slot_q;
  logic [TIME_W-1:0]    p1_time_q, p2_time_q, p3_time_q;
  logic [2:0][SUM_W-1:0]  sum_q, sum_d, p2_sum_q;
  logic [2:0][PROD_W-1:0] prod_q;
  tri_mag_t             mag_c, old_c;

  assign ptr_d = (ptr_q == PTR_W'(AVG_LEN - 1)) ? '0 : ptr_q + 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = mag_of(sample_i.acc[i], cfg_i.bias[i]);
      old_c[i] = rd_ok_q ? rd_q[i] : '0;
      sum_d[i] = sum_q[i] - SUM_W'(old_c[i]) + SUM_W'(p1_mag_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      row_ok_q   <= '0;
      rd_ok_q    <= 1'b0;
      sum_q      <= '0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= in_valid_i;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      rd_ok_q    <= row_ok_q[ptr_q];
      if (in_valid_i) begin
        ptr_q <= ptr_d;
      end
      if (p1_valid_q) begin
        sum_q               <= sum_d;
        row_ok_q[p1_slot_q] <= 1'b1;
      end
    end
  end

  // memory port: read at the accepting edge, write in the following cycle
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[ptr_q];
    if (p1_valid_q) begin
      mem_q[p1_slot_q] <= p1_mag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_mag_q  <= mag_c;
    p1_slot_q <= ptr_q;
    p1_time_q <= sample_i.time_us;
    p2_sum_q  <= sum_d;
    p2_time_q <= p1_time_q;
    p3_time_q <= p2_time_q;
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= p2_sum_q[i] * RECIP;
    end
  end

  always_comb begin
    beat_o.valid   = p3_valid_q;
    beat_o.time_us = p3_time_q;
    for (int i = 0; i < 3; i++) begin
      beat_o.avg[i] = prod_q[i][SHIFT +: MAG_W];
    end
  end

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(AVG_LEN - 1))
    else $error("ring pointer out of range");

  // read of one entry and write of another never hit the same row
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && p1_valid_q |-> ptr_q != p1_slot_q)
    else $error("read and write collide on one row");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q |-> ##2 beat_o.valid)
    else $error("average pipeline dropped a beat");

endmodule

`default_nettype wire

@@ hdl/dts_track.sv @@
// ----------------------------------------------------------------------------
// dts_track
// Window min/max tracking, threshold latch, axis pick and step detection.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dts_pkg::avg_beat_t beat_i,
  input  dts_pkg::cfg_t      cfg_i,
  output logic               res_valid_o,
  output dts_pkg::result_t   res_o
);
  import dts_pkg::*;

  tri_mag_t            min_q, max_q, thr_q, thr_c, swing_c;
  axis_e               axis_q, sel_c, axis_c;
  logic [TIME_W-1:0]   last_q, elapsed_c;
  logic                ended_c, chg_c;

  logic                p4_valid_q, p4_chg_q, p4_end_q;
  axis_e               p4_axis_q;
  logic [MAG_W-1:0]    p4_cur_q, p4_thr_q;
  logic [MAG_W-1:0]    held_q, held_d, old_c, diff_c;
  logic [STEPS_W-1:0]  total_q, total_d;
  logic                moved_c, step_c;

  // window stage
  always_comb begin
    logic [MAG_W:0] mid;
    elapsed_c = beat_i.time_us - last_q;
    ended_c   = elapsed_c >= TIME_W'(cfg_i.window_us);
    for (int i = 0; i < 3; i++) begin
      mid        = {1'b0, min_q[i]} + {1'b0, max_q[i]};
      thr_c[i]   = mid[MAG_W:1];
      swing_c[i] = (max_q[i] >= min_q[i]) ? max_q[i] - min_q[i] : '0;
    end
    if (swing_c[0] >= swing_c[1] && swing_c[0] >= swing_c[2]) begin
      sel_c = AXIS_X;
    end else if (swing_c[1] >= swing_c[0] && swing_c[1] >= swing_c[2]) begin
      sel_c = AXIS_Y;
    end else begin
      sel_c = AXIS_Z;
    end
    axis_c = ended_c ? sel_c : axis_q;
    chg_c  = ended_c && (sel_c != axis_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= '0;
      max_q      <= '0;
      thr_q      <= '0;
      axis_q     <= AXIS_X;
      last_q     <= '0;
      p4_valid_q <= 1'b0;
      held_q     <= '0;
      total_q    <= '0;
    end else begin
      p4_valid_q <= beat_i.valid;
      if (beat_i.valid) begin
        if (ended_c) begin
          thr_q  <= thr_c;
          min_q  <= beat_i.avg;
          max_q  <= beat_i.avg;
          axis_q <= sel_c;
          last_q <= beat_i.time_us;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (beat_i.avg[i] < min_q[i]) min_q[i] <= beat_i.avg[i];
            if (beat_i.avg[i] > max_q[i]) max_q[i] <= beat_i.avg[i];
          end
        end
      end
      if (p4_valid_q) begin
        held_q  <= held_d;
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p4_axis_q <= axis_c;
    p4_chg_q  <= chg_c;
    p4_end_q  <= ended_c;
    p4_cur_q  <= pick(beat_i.avg, axis_c);
    p4_thr_q  <= ended_c ? pick(thr_c, sel_c) : pick(thr_q, axis_q);
  end

  // step stage; an axis change re-seeds the held sample, so no step then
  always_comb begin
    old_c   = p4_chg_q ? p4_cur_q : held_q;
    diff_c  = (p4_cur_q >= old_c) ? p4_cur_q - old_c : old_c - p4_cur_q;
    moved_c = diff_c > cfg_i.step_prec;
    step_c  = moved_c && (old_c > p4_thr_q) && (p4_cur_q < p4_thr_q);
    held_d  = (moved_c || p4_chg_q) ? p4_cur_q : held_q;
    total_d = total_q + STEPS_W'(step_c);
  end

  assign res_valid_o        = p4_valid_q;
  assign res_o.total_steps  = total_d;
  assign res_o.step_seen    = step_c;
  assign res_o.axis_in_use  = p4_axis_q;
  assign res_o.window_ended = p4_end_q;

  a_chg_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p4_valid_q && p4_chg_q |-> !step_c)
    else $error("step counted on an axis change");

  a_chg_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p4_valid_q && !p4_end_q |-> !p4_chg_q)
    else $error("axis changed without a window end");

  a_window_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i.valid && ended_c |=> last_q == $past(beat_i.time_us))
    else $error("window start time not latched");

  a_total_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> total_q == $past(res_o.total_steps))
    else $error("step total lost");

endmodule

`default_nettype wire

@@ hdl/dts_ofifo.sv @@
// ----------------------------------------------------------------------------
// dts_ofifo
// Result queue between the pipeline and the master stream side.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_ofifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  dts_pkg::result_t              data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output dts_pkg::result_t              data_o,
  output logic [dts_pkg::OFIFO_CW-1:0]  count_o
);
  import dts_pkg::*;

  result_t               buf_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]   wr_q, rd_q;
  logic [OFIFO_CW-1:0]   cnt_q;
  logic                  pop_ok;

  assign valid_o = cnt_q != '0;
  assign data_o  = buf_q[rd_q];
  assign count_o = cnt_q;
  assign pop_ok  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_ok) rd_q <= rd_q + 1'b1;
      case ({push_i, pop_ok})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != OFIFO_CW'(OFIFO_DEPTH))
    else $error("push into full result queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OFIFO_CW'(OFIFO_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OFIFO_AW'(cnt_q) == OFIFO_AW'(wr_q - rd_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ hdl/dynamic_threshold_step_counter.sv @@
// ----------------------------------------------------------------------------
// dynamic_threshold_step_counter
// Step counter on three acceleration axes with a per-window dynamic threshold.
// ----------------------------------------------------------------------------
//  port group   | dir | carries
//  s_axis_*     | in  | sample_x, sample_y, sample_z, time_us
//  m_axis_*     | out | total_steps, step_seen, axis_in_use, window_ended
//  cfg_*        | in  | bias_x/y/z, step_precision, window_us (write only)
//
//  One sample per cycle sustained while the result queue has room; a result
//  passes the p1..p4 registers and the result queue before m_axis shows it.
//  The limit is the averaging memory's one read-modify-write per cycle.
//  Reset clears the averaging rows through per-row valid bits: no clearing
//  pass, a sample is taken as soon as reset is released.
//  An 8-entry result queue decouples the sides; s_axis_tready drops only
//  when queued plus in-flight results reach 8.
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_threshold_step_counter #(
  parameter int unsigned AVG_LEN = 20   // moving average length, 2..64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [18:0] sample_x, [37:19] sample_y, [56:38] sample_z, [104:57] time_us
  input  logic [dts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] total_steps, [32] step_seen, [34:33] axis_in_use, [35] window_ended
  output logic [dts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [dts_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [dts_pkg::WIN_W-1:0]         cfg_wdata_i
);
  import dts_pkg::*;

  cfg_t                 cfg_q;
  sample_t              sample;
  avg_beat_t            beat;
  logic                 res_valid;
  result_t              res, q_data;
  logic [OFIFO_CW-1:0]  q_cnt;
  logic [2:0]           inflight_q;   // accepted, not yet in the queue
  logic                 s_accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bias      <= '0;
      cfg_q.step_prec <= STEP_PREC_RST;
      cfg_q.window_us <= WINDOW_US_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIAS_X:    cfg_q.bias[0]   <= cfg_wdata_i[MAG_W-1:0];
        REG_BIAS_Y:    cfg_q.bias[1]   <= cfg_wdata_i[MAG_W-1:0];
        REG_BIAS_Z:    cfg_q.bias[2]   <= cfg_wdata_i[MAG_W-1:0];
        REG_STEP_PREC: cfg_q.step_prec <= cfg_wdata_i[MAG_W-1:0];
        REG_WINDOW_US: cfg_q.window_us <= cfg_wdata_i;
        default:       cfg_q           <= cfg_q;   // unknown index ignored
      endcase
    end
  end

  // credit check: every accepted sample has a queue slot waiting for it
  assign s_axis_tready = (q_cnt + OFIFO_CW'(inflight_q)) < OFIFO_CW'(OFIFO_DEPTH);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      case ({s_accept, res_valid})
        2'b10:   inflight_q <= inflight_q + 1'b1;
        2'b01:   inflight_q <= inflight_q - 1'b1;
        default: inflight_q <= inflight_q;
      endcase
    end
  end

  assign sample.acc[0]  = s_axis_tdata[18:0];
  assign sample.acc[1]  = s_axis_tdata[37:19];
  assign sample.acc[2]  = s_axis_tdata[56:38];
  assign sample.time_us = s_axis_tdata[104:57];

  dts_avg #(
    .AVG_LEN (AVG_LEN)
  ) u_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_accept),
    .sample_i   (sample),
    .cfg_i      (cfg_q),
    .beat_o     (beat)
  );

  dts_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dts_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (q_data),
    .count_o (q_cnt)
  );

  assign m_axis_tdata = {4'b0000, q_data.window_ended, q_data.axis_in_use,
                         q_data.step_seen, q_data.total_steps};

  // pipeline is 4 deep
  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more samples in flight than pipeline stages");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt + OFIFO_CW'(inflight_q)) <= OFIFO_CW'(OFIFO_DEPTH))
    else $error("result credits overrun");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |-> ##4 res_valid)
    else $error("accepted sample produced no result");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dynamic-threshold step counter. Timestamped
// three-axis samples go in over the sample stream; a behavioural model of the
// pedometer predicts each result and the output stream is compared field by
// field. Settings are changed only while the block is idle.
// ----------------------------------------------------------------------------

module tb;
  import dts_pkg::*;

  localparam int unsigned AVG_DEPTH     = 20;
  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 12;      // idle margin after the last result
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SAMPLE_LIM    = 200000;  // legal sample and bias swing, milli units

  // indexes with no register behind them; writes there must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [MAG_W-1:0] acc_x;
    logic signed [MAG_W-1:0] acc_y;
    logic signed [MAG_W-1:0] acc_z;
    logic [TIME_W-1:0]       stamp;
  } accel_sample_t;

  typedef struct {
    logic [STEPS_W-1:0] steps;
    logic               seen;
    axis_e              axis;
    logic               ended;
  } gait_report_t;

  // --------------------------------------------------------------------------
  // DUT and its stimulus signals; every input has a known value from time 0
  // --------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [18:0] sample_x, [37:19] sample_y, [56:38] sample_z, [104:57] time_us
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [31:0] total_steps, [32] step_seen, [34:33] axis_in_use, [35] window_ended
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [IDX_W-1:0]       cfg_idx_i     = REG_BIAS_X;
  logic [WIN_W-1:0]       cfg_wdata_i   = '0;

  dynamic_threshold_step_counter #(
    .AVG_LEN(AVG_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Pedometer model state: a mirror of the settings plus the block's state,
  // all at their reset values
  // --------------------------------------------------------------------------
  logic signed [MAG_W-1:0] bias_m [3]                  = '{default: '0};
  logic [MAG_W-1:0]        prec_m                      = STEP_PREC_RST;
  logic [WIN_W-1:0]        win_len_m                   = WINDOW_US_RST;
  logic [MAG_W-1:0]        mag_hist [3][AVG_DEPTH]     = '{default: '0};
  logic [31:0]             mag_sum [3]                 = '{default: '0};
  int unsigned             fill_slot                   = 0;
  logic [MAG_W-1:0]        lo_avg [3]                  = '{default: '0};
  logic [MAG_W-1:0]        hi_avg [3]                  = '{default: '0};
  logic [MAG_W-1:0]        thr_avg [3]                 = '{default: '0};
  axis_e                   live_axis                   = AXIS_X;
  logic [MAG_W-1:0]        held                        = '0;
  logic [TIME_W-1:0]       win_start                   = '0;
  logic [STEPS_W-1:0]      step_cnt                    = '0;

  accel_sample_t sample_queue [$];   // samples waiting for the driver
  gait_report_t  reports_due [$];    // predicted results, oldest first

  logic [TIME_W-1:0] clock_us     = '0;   // timestamp of the last staged sample
  bit                steady       = 1'b0; // no idling on either side while set
  int unsigned       mismatch_cnt = 0;
  int unsigned       results_seen = 0;
  int unsigned       cycle_cnt    = 0;

  // |raw - bias| in a bit more than the entry width, saturated to the entry
  function automatic logic [MAG_W-1:0] offset_mag(input logic signed [MAG_W-1:0] raw,
                                                  input logic signed [MAG_W-1:0] bias);
    logic signed [MAG_W:0] d;
    d = raw - bias;
    if (d < 0) d = -d;
    return d[MAG_W] ? {MAG_W{1'b1}} : d[MAG_W-1:0];
  endfunction

  // One accepted sample through the pedometer: averages, window, step test.
  task automatic advance_pedometer(input accel_sample_t smp, output gait_report_t rep);
    logic [MAG_W-1:0] mag [3];
    logic [MAG_W-1:0] avg [3];
    logic [MAG_W-1:0] swing [3];
    logic [MAG_W-1:0] cur;
    logic [MAG_W-1:0] prev;
    logic [MAG_W-1:0] thr;
    logic [MAG_W-1:0] spread;
    axis_e            pick_ax;
    mag[0] = offset_mag(smp.acc_x, bias_m[0]);
    mag[1] = offset_mag(smp.acc_y, bias_m[1]);
    mag[2] = offset_mag(smp.acc_z, bias_m[2]);
    for (int i = 0; i < 3; i++) begin
      mag_sum[i] = mag_sum[i] - 32'(mag_hist[i][fill_slot]) + 32'(mag[i]);
      mag_hist[i][fill_slot] = mag[i];
      avg[i] = MAG_W'(mag_sum[i] / AVG_DEPTH);
    end
    fill_slot = (fill_slot + 1 >= AVG_DEPTH) ? 0 : fill_slot + 1;

    rep.ended = 1'b0;
    rep.seen  = 1'b0;
    // elapsed time wraps at the timestamp width
    if (TIME_W'(smp.stamp - win_start) >= TIME_W'(win_len_m)) begin
      rep.ended = 1'b1;
      win_start = smp.stamp;
      for (int i = 0; i < 3; i++) begin
        thr_avg[i] = MAG_W'(({1'b0, lo_avg[i]} + {1'b0, hi_avg[i]}) >> 1);
        swing[i]   = (hi_avg[i] >= lo_avg[i]) ? hi_avg[i] - lo_avg[i] : '0;
        lo_avg[i]  = avg[i];
        hi_avg[i]  = avg[i];
      end
      // ties go to x, then y
      if (swing[0] >= swing[1] && swing[0] >= swing[2]) pick_ax = AXIS_X;
      else if (swing[1] >= swing[2]) pick_ax = AXIS_Y;
      else pick_ax = AXIS_Z;
      // a change of axis re-seeds the held value, so no step on this sample
      if (pick_ax != live_axis) held = avg[pick_ax];
      live_axis = pick_ax;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (avg[i] < lo_avg[i]) lo_avg[i] = avg[i];
        if (avg[i] > hi_avg[i]) hi_avg[i] = avg[i];
      end
    end

    cur    = avg[live_axis];
    prev   = held;
    thr    = thr_avg[live_axis];
    spread = (cur >= prev) ? cur - prev : prev - cur;
    if (spread > prec_m) begin
      held = cur;
      // strictly above, then strictly below: touching the threshold is no step
      if (prev > thr && cur < thr) begin
        step_cnt = step_cnt + 1'b1;
        rep.seen = 1'b1;
      end
    end
    rep.steps = step_cnt;
    rep.axis  = live_axis;
  endtask

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_cnt++;
    $display("%0t result %0d: %s got %0d expected %0d", $time, results_seen, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Sample driver: presents the queue, predicts each accepted transaction
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : feed
    gait_report_t  rep;
    accel_sample_t in_flight;
    int unsigned   send_pause;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_pause = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_pedometer(in_flight, rep);
        reports_due.push_back(rep);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_pause > 0) begin
          send_pause--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_flight = sample_queue.pop_front();
          s_axis_tdata  <= IN_TDATA_W'({in_flight.stamp, in_flight.acc_z,
                                        in_flight.acc_y, in_flight.acc_x});
          s_axis_tvalid <= 1'b1;
          if (!steady && $urandom_range(0, 99) < 35) send_pause = pause_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random back-pressure, compares each result transaction
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : watch
    gait_report_t want;
    int unsigned  recv_pause;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_pause = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reports_due.size() == 0) begin
          flag_mismatch("result with nothing pending", 32'(m_axis_tdata[31:0]), '0);
        end else begin
          want = reports_due.pop_front();
          if (m_axis_tdata[31:0] !== want.steps)
            flag_mismatch("total_steps", m_axis_tdata[31:0], want.steps);
          if (m_axis_tdata[32] !== want.seen)
            flag_mismatch("step_seen", 32'(m_axis_tdata[32]), 32'(want.seen));
          if (m_axis_tdata[34:33] !== want.axis)
            flag_mismatch("axis_in_use", 32'(m_axis_tdata[34:33]), 32'(want.axis));
          if (m_axis_tdata[35] !== want.ended)
            flag_mismatch("window_ended", 32'(m_axis_tdata[35]), 32'(want.ended));
        end
        results_seen++;
      end
      if (!steady && recv_pause == 0 && $urandom_range(0, 99) < 15) recv_pause = pause_len();
      if (recv_pause > 0) begin
        recv_pause--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("dynamic_threshold_step_counter test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_sample(input int ax, input int ay, input int az,
                              input logic [TIME_W-1:0] dt);
    accel_sample_t smp;
    clock_us  = clock_us + dt;
    smp.acc_x = MAG_W'(ax);
    smp.acc_y = MAG_W'(ay);
    smp.acc_z = MAG_W'(az);
    smp.stamp = clock_us;
    sample_queue.push_back(smp);
  endtask

  // place a magnitude on the side of the bias that keeps the sample in range
  function automatic int biased(input int a, input int mag);
    int b;
    int v;
    b = int'(bias_m[a]);
    v = (b > 0) ? b - mag : b + mag;
    if (v > SAMPLE_LIM) v = SAMPLE_LIM;
    if (v < -SAMPLE_LIM) v = -SAMPLE_LIM;
    return v;
  endfunction

  // walking gait: triangle wave on one axis with a period of 30 to 60 samples, the others quiet
  task automatic queue_walk(input int n);
    int lead;
    int amp;
    int period;
    int half;
    int ph;
    int tri_v;
    int base;
    int dt;
    int mags [3];
    lead   = $urandom_range(0, 2);
    amp    = $urandom_range(5000, 80000);
    period = $urandom_range(30, 60);
    half   = period / 2;
    base   = amp + int'($urandom_range(500, 3000));
    dt     = $urandom_range(8000, 12000);
    for (int k = 0; k < n; k++) begin
      ph = k % period;
      tri_v = (ph < half) ? (2 * amp * ph) / half - amp
                          : amp - (2 * amp * (ph - half)) / (period - half);
      for (int a = 0; a < 3; a++)
        mags[a] = (a == lead) ? base + tri_v + int'($urandom_range(0, 400))
                              : 20000 + int'($urandom_range(0, 800));
      queue_sample(biased(0, mags[0]), biased(1, mags[1]), biased(2, mags[2]),
                   TIME_W'(dt + int'($urandom_range(0, 200))));
    end
  endtask

  // anything in range, with occasional large time jumps
  task automatic queue_noise(input int n);
    int unsigned r;
    logic [TIME_W-1:0] dt;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) dt = $urandom_range(0, 20000);
      else if (r < 92) dt = $urandom_range(0, 1000000);
      else dt = $urandom;
      queue_sample(int'($urandom_range(0, 2 * SAMPLE_LIM)) - SAMPLE_LIM,
                   int'($urandom_range(0, 2 * SAMPLE_LIM)) - SAMPLE_LIM,
                   int'($urandom_range(0, 2 * SAMPLE_LIM)) - SAMPLE_LIM, dt);
    end
  endtask

  // four samples following a wave on the chosen axes, the last one closing the window
  task automatic queue_swing_window(input bit vary_x, input bit vary_y, input bit vary_z);
    int wave [4] = '{60000, -90000, 20000, 35000};
    for (int k = 0; k < 4; k++)
      queue_sample(vary_x ? wave[k] : 7000, vary_y ? wave[k] : 7000,
                   vary_z ? wave[k] : 7000, (k == 3) ? TIME_W'(500000) : TIME_W'(1000));
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || s_axis_tvalid || reports_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BIAS_X:    bias_m[0] = val[MAG_W-1:0];
      REG_BIAS_Y:    bias_m[1] = val[MAG_W-1:0];
      REG_BIAS_Z:    bias_m[2] = val[MAG_W-1:0];
      REG_STEP_PREC: prec_m    = val[MAG_W-1:0];
      REG_WINDOW_US: win_len_m = val;
      default: ;
    endcase
  endtask

  // walking chunks are trimmed so a phase stays close to n samples
  task automatic run_phase(input int n, input int noise_pct);
    int chunk;
    if ($urandom_range(0, 99) < 30) clock_us = TIME_W'({$urandom, $urandom});
    while (sample_queue.size() < n) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        queue_noise($urandom_range(2, 8));
      end else begin
        chunk = $urandom_range(40, 90);
        if (chunk > n - sample_queue.size()) chunk = n - sample_queue.size();
        queue_walk(chunk);
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, reset settings (500 ms window). Field extremes first.
    queue_sample(0, 0, 0, 0);
    queue_sample(SAMPLE_LIM, -SAMPLE_LIM, 0, 1000);
    queue_sample(-SAMPLE_LIM, SAMPLE_LIM, SAMPLE_LIM, 1000);
    queue_sample(0, -SAMPLE_LIM, -SAMPLE_LIM, 1000);
    queue_sample(150000, 150000, 0, 1000);
    // one microsecond short of the window, then exactly on it
    queue_sample(-150000, 150000, 0, 495999);
    queue_sample(150000, -150000, 0, 1);
    // identical x/y keeps their swings equal: tie goes to x
    queue_swing_window(1'b1, 1'b1, 1'b0);
    // identical y/z: tie goes to y, axis change re-seeds the held value
    queue_swing_window(1'b0, 1'b1, 1'b1);
    // z alone swings
    queue_swing_window(1'b0, 1'b0, 1'b1);
    // timestamp wrap: jump near the top, a short wrapped gap, then a full window
    clock_us = {TIME_W{1'b1}} - TIME_W'(999);
    queue_sample(-1, 1, -1, 0);
    queue_sample(1, -1, 1, 2000);
    queue_sample(99999, -99999, 12345, 499000);
    wait_idle();

    // reset settings, ordinary walking
    run_phase(105, 20);

    // extreme biases, no hysteresis, a window closing on almost every sample,
    // back-to-back transactions
    write_reg(REG_BIAS_X, -SAMPLE_LIM);
    write_reg(REG_BIAS_Y, SAMPLE_LIM);
    write_reg(REG_BIAS_Z, int'($urandom_range(0, 2 * SAMPLE_LIM)) - SAMPLE_LIM);
    write_reg(REG_STEP_PREC, '0);
    write_reg(REG_WINDOW_US, 32'd1);
    steady = 1'b1;
    run_phase(60, 40);

    // hysteresis too wide for any step, a window that almost never closes;
    // stray writes to unused indexes must change nothing
    write_reg(REG_BIAS_X, SAMPLE_LIM);
    write_reg(REG_BIAS_Y, -SAMPLE_LIM);
    write_reg(REG_BIAS_Z, '0);
    write_reg(REG_STEP_PREC, 32'd400000);
    write_reg(REG_WINDOW_US, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    steady = 1'b0;
    run_phase(60, 30);

    // realistic settings, drawn at random
    repeat (4) begin
      write_reg(REG_BIAS_X, int'($urandom_range(0, 10000)) - 5000);
      write_reg(REG_BIAS_Y, int'($urandom_range(0, 10000)) - 5000);
      write_reg(REG_BIAS_Z, int'($urandom_range(0, 10000)) - 5000);
      write_reg(REG_STEP_PREC, $urandom_range(0, 2000));
      write_reg(REG_WINDOW_US, $urandom_range(200000, 800000));
      steady = ($urandom_range(0, 3) == 0);
      run_phase(105, 20);
    end

    if (mismatch_cnt == 0) begin
      $display("dynamic_threshold_step_counter test passed");
    end else begin
      $display("dynamic_threshold_step_counter test failed");
    end
    $finish;
  end

endmodule
